@@ hw/rtl/scp_pkg.sv @@
`timescale 1ns / 1ps
package scp_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_KEY_BITS    = 64;
  localparam int DEF_VALUE_BITS  = 32;

  // fixed field widths on the ports
  localparam int CAP_W = 7;
  localparam int KEY_W = 64;
  localparam int VAL_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // request op carried on in_tuser
  typedef enum logic {
    OP_LOOKUP        = 1'b0,
    OP_LOOKUP_INSERT = 1'b1
  } scp_op_t;

  // in_tdata: key, insert_value
  localparam int IN_TDATA_W = 96;

  // out_tdata: hit, hit_value, did_insert, did_evict, evicted_key, zero pad
  localparam int OUT_HIT_LSB  = 0;
  localparam int OUT_HVAL_LSB = 1;
  localparam int OUT_INS_LSB  = OUT_HVAL_LSB + VAL_W;
  localparam int OUT_EV_LSB   = OUT_INS_LSB + 1;
  localparam int OUT_EKEY_LSB = OUT_EV_LSB + 1;
  localparam int OUT_USED_W   = OUT_EKEY_LSB + KEY_W;
  localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

endpackage

@@ hw/rtl/sieve_cache_policy.sv @@
`timescale 1ns / 1ps
// SIEVE cache, fully associative key/value store.
//
// in_*  : one request item per handshake. in_tuser = op (0 lookup, 1 lookup or
//         insert on miss), in_tdata = {insert_value, key}.
// out_* : one result item per request. out_tdata from bit 0 up: hit, hit_value,
//         did_insert, did_evict, evicted_key, zero pad.
// cfg_* : capacity register, to be written while the block is idle; the block itself does not enforce this.
//
// An item is processed by a sequencer around one set of tables (key, value,
// visited, links) with a registered read. The tag search scans one slot per
// cycle and stops at a hit; a miss scans all MAX_ENTRIES slots. An eviction
// walk reads and then checks one slot per hand step (EVRD, EVCK), at most
// MAX_ENTRIES+1 steps, and insertion follows in INS, plus LINK when the list
// was not empty. in_tready is high only while the sequencer is idle.
// Results go to an output register; a new item is taken while a result still
// waits there, and the sequencer holds its finished result until the register
// frees up. Reset empties the cache (valid bits cleared at once) and sets
// capacity to 64; no clearing pass is needed.
module sieve_cache_policy #(
  parameter int MAX_ENTRIES = scp_pkg::DEF_MAX_ENTRIES,
  parameter int KEY_BITS    = scp_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = scp_pkg::DEF_VALUE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [scp_pkg::IN_TDATA_W-1:0] in_tdata,   // key[63:0], insert_value[95:64]
  input  logic                           in_tuser,   // op
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [scp_pkg::OUT_TDATA_W-1:0] out_tdata, // hit, hit_value, did_insert,
                                                      // did_evict, evicted_key
  input  logic                           cfg_wr_en,
  input  logic [scp_pkg::CAP_W-1:0]      cfg_wr_data
);
  import scp_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PTR_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (PTR_W > CAP_W) ? PTR_W : CAP_W;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_ENTRIES);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_EVRD = 7'b0000100,
    ST_EVCK = 7'b0001000,
    ST_INS  = 7'b0010000,
    ST_LINK = 7'b0100000,
    ST_DONE = 7'b1000000
  } scp_state_t;

  scp_state_t state_r, state_nxt;

  // slot tables
  logic [KEY_BITS-1:0]   key_mem   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] val_mem   [MAX_ENTRIES];
  logic                  vis_mem   [MAX_ENTRIES];
  logic [PTR_W-1:0]      newer_mem [MAX_ENTRIES];
  logic [PTR_W-1:0]      older_mem [MAX_ENTRIES];

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  vis_q;
  logic [PTR_W-1:0]      newer_q, older_q;

  logic [IDX_W-1:0] rd_idx;
  logic             kv_we;
  logic             vis_we, vis_wd;
  logic [IDX_W-1:0] vis_wa;
  logic             newer_we, older_we;
  logic [IDX_W-1:0] newer_wa, older_wa;
  logic [PTR_W-1:0] newer_wd, older_wd;

  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [PTR_W-1:0] newest_r, newest_nxt, oldest_r, oldest_nxt, hand_r, hand_nxt;
  logic [PTR_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;

  logic                op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] ival_r, ival_nxt;
  logic [PTR_W-1:0]    scan_r, scan_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    cmp_r, cmp_nxt;
  logic                free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0]    free_r, free_nxt;
  logic [PTR_W-1:0]    cur_r, cur_nxt;

  logic              res_hit_r, res_hit_nxt, res_ins_r, res_ins_nxt, res_ev_r, res_ev_nxt;
  logic [VAL_W-1:0]  res_hval_r, res_hval_nxt;
  logic [KEY_W-1:0]  res_ekey_r, res_ekey_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [CMP_W-1:0] eff_cap;
  logic             need_evict;
  logic             issue;
  logic [PTR_W-1:0] start_ptr, walk_nxt, oldest_upd;
  logic [IDX_W-1:0] cur_idx;

  assign cur_idx = cur_r[IDX_W-1:0];
  assign issue   = (scan_r != NIL);
  assign rd_idx  = (state_r == ST_SCAN) ? scan_r[IDX_W-1:0] : cur_idx;

  always_comb begin
    if (cap_r == '0) eff_cap = CMP_W'(1);
    else if (CMP_W'(cap_r) > CMP_W'(MAX_ENTRIES)) eff_cap = CMP_W'(MAX_ENTRIES);
    else eff_cap = CMP_W'(cap_r);
  end
  assign need_evict = (count_r != '0) && (CMP_W'(count_r) >= eff_cap);
  assign start_ptr  = (hand_r != NIL) ? hand_r : oldest_r;
  assign walk_nxt   = (newer_q != NIL) ? newer_q : oldest_r;
  assign oldest_upd = (older_q == NIL) ? newer_q : oldest_r;

  always_ff @(posedge clk) begin
    key_q   <= key_mem[rd_idx];
    val_q   <= val_mem[rd_idx];
    vis_q   <= vis_mem[rd_idx];
    newer_q <= newer_mem[rd_idx];
    older_q <= older_mem[rd_idx];
    if (kv_we) begin
      key_mem[free_r] <= key_r;
      val_mem[free_r] <= ival_r;
    end
    if (vis_we)   vis_mem[vis_wa]     <= vis_wd;
    if (newer_we) newer_mem[newer_wa] <= newer_wd;
    if (older_we) older_mem[older_wa] <= older_wd;
  end

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    newest_nxt   = newest_r;
    oldest_nxt   = oldest_r;
    hand_nxt     = hand_r;
    count_nxt    = count_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    ival_nxt     = ival_r;
    scan_nxt     = scan_r;
    pend_nxt     = pend_r;
    cmp_nxt      = cmp_r;
    free_ok_nxt  = free_ok_r;
    free_nxt     = free_r;
    cur_nxt      = cur_r;
    res_hit_nxt  = res_hit_r;
    res_hval_nxt = res_hval_r;
    res_ins_nxt  = res_ins_r;
    res_ev_nxt   = res_ev_r;
    res_ekey_nxt = res_ekey_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    kv_we    = 1'b0;
    vis_we   = 1'b0;
    vis_wa   = cmp_r;
    vis_wd   = 1'b0;
    newer_we = 1'b0;
    newer_wa = cur_idx;
    newer_wd = NIL;
    older_we = 1'b0;
    older_wa = cur_idx;
    older_wd = NIL;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt       = in_tuser;
          key_nxt      = KEY_BITS'(in_tdata[KEY_W-1:0]);
          ival_nxt     = VALUE_BITS'(in_tdata[KEY_W +: VAL_W]);
          scan_nxt     = '0;
          pend_nxt     = 1'b0;
          free_ok_nxt  = 1'b0;
          res_hit_nxt  = 1'b0;
          res_hval_nxt = '0;
          res_ins_nxt  = 1'b0;
          res_ev_nxt   = 1'b0;
          res_ekey_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read slot scan_r while comparing the slot read last cycle
        if (issue) begin
          if (!valid_r[scan_r[IDX_W-1:0]] && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_nxt    = scan_r[IDX_W-1:0];
          end
          cmp_nxt  = scan_r[IDX_W-1:0];
          scan_nxt = scan_r + PTR_W'(1);
        end
        pend_nxt = issue;
        if (pend_r && valid_r[cmp_r] && (key_q == key_r)) begin
          vis_we       = 1'b1;
          vis_wa       = cmp_r;
          vis_wd       = 1'b1;
          res_hit_nxt  = 1'b1;
          res_hval_nxt = VAL_W'(val_q);
          state_nxt    = ST_DONE;
        end else if (!issue && !pend_r) begin
          if (op_r == OP_LOOKUP) begin
            state_nxt = ST_DONE;
          end else if (need_evict) begin
            cur_nxt = start_ptr;
            if (start_ptr == NIL) begin
              res_ev_nxt = 1'b1;
              state_nxt  = ST_INS;
            end else begin
              state_nxt = ST_EVRD;
            end
          end else begin
            state_nxt = ST_INS;
          end
        end
      end
      ST_EVRD: state_nxt = ST_EVCK;
      ST_EVCK: begin
        if (vis_q) begin
          vis_we    = 1'b1;
          vis_wa    = cur_idx;
          vis_wd    = 1'b0;
          cur_nxt   = walk_nxt;
          state_nxt = ST_EVRD;
        end else begin
          if (older_q != NIL) begin
            newer_we = 1'b1;
            newer_wa = older_q[IDX_W-1:0];
            newer_wd = newer_q;
          end else begin
            oldest_nxt = newer_q;
          end
          if (newer_q != NIL) begin
            older_we = 1'b1;
            older_wa = newer_q[IDX_W-1:0];
            older_wd = older_q;
          end else begin
            newest_nxt = older_q;
          end
          hand_nxt           = (newer_q != NIL) ? newer_q : oldest_upd;
          valid_nxt[cur_idx] = 1'b0;
          count_nxt          = count_r - PTR_W'(1);
          res_ev_nxt         = 1'b1;
          res_ekey_nxt       = KEY_W'(key_q);
          // freed slot competes with the lowest free slot seen in the scan
          free_ok_nxt = 1'b1;
          if (!(free_ok_r && (free_r < cur_idx))) free_nxt = cur_idx;
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        state_nxt = ST_DONE;
        if (free_ok_r) begin
          kv_we    = 1'b1;
          vis_we   = 1'b1;
          vis_wa   = free_r;
          vis_wd   = 1'b0;
          newer_we = 1'b1;
          newer_wa = free_r;
          newer_wd = NIL;
          older_we = 1'b1;
          older_wa = free_r;
          older_wd = newest_r;
          valid_nxt[free_r] = 1'b1;
          count_nxt   = count_r + PTR_W'(1);
          res_ins_nxt = 1'b1;
          newest_nxt  = PTR_W'(free_r);
          cur_nxt     = newest_r;
          if (newest_r == NIL) begin
            oldest_nxt = PTR_W'(free_r);
            hand_nxt   = PTR_W'(free_r);
          end else begin
            state_nxt = ST_LINK;
          end
        end
      end
      ST_LINK: begin
        newer_we  = 1'b1;
        newer_wa  = cur_idx;
        newer_wd  = PTR_W'(free_r);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[OUT_HIT_LSB]          = res_hit_r;
          out_data_nxt[OUT_HVAL_LSB +: VAL_W] = res_hval_r;
          out_data_nxt[OUT_INS_LSB]          = res_ins_r;
          out_data_nxt[OUT_EV_LSB]           = res_ev_r;
          out_data_nxt[OUT_EKEY_LSB +: KEY_W] = res_ekey_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      newest_r    <= NIL;
      oldest_r    <= NIL;
      hand_r      <= NIL;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      free_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      hand_r      <= hand_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      free_ok_r   <= free_ok_nxt;
      if (cfg_wr_en) cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    ival_r     <= ival_nxt;
    scan_r     <= scan_nxt;
    cmp_r      <= cmp_nxt;
    free_r     <= free_nxt;
    cur_r      <= cur_nxt;
    res_hit_r  <= res_hit_nxt;
    res_hval_r <= res_hval_nxt;
    res_ins_r  <= res_ins_nxt;
    res_ev_r   <= res_ev_nxt;
    res_ekey_r <= res_ekey_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/scp_checker.sv @@
`timescale 1ns / 1ps
module scp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [scp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import scp_pkg::*;

  // result held while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // a hit never inserts, and an eviction only happens for an insert
  a_hit_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[OUT_HIT_LSB] && out_tdata[OUT_INS_LSB]))
    else $error("hit and insert together");

  a_ev_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_EV_LSB] |-> out_tdata[OUT_INS_LSB])
    else $error("eviction without insert");

  a_miss_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[OUT_HIT_LSB] |-> out_tdata[OUT_HVAL_LSB +: VAL_W] == '0)
    else $error("value on a miss");

endmodule

bind sieve_cache_policy scp_checker u_scp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
